// File: rtl/core/fosq_pkg.sv
// Shared types and constants for the option-select qualifier.
package fosq_pkg;

   localparam int unsigned TICK_W = 16;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [TICK_W-1:0] ASSERT_TICKS_RESET   = 16'd3;
   localparam logic [TICK_W-1:0] DEASSERT_TICKS_RESET = 16'd300;
   localparam logic [TICK_W-1:0] RUN_COUNT_MAX        = 16'hFFFF;

   // Register indexes on the csr port.
   typedef enum logic [0:0] {
      CSR_ASSERT_TICKS   = 1'b0,
      CSR_DEASSERT_TICKS = 1'b1
   } csr_index_type;

   // One pin sample as captured from the request channel.
   typedef struct packed {
      logic tick;
      logic drive_sel_a;
      logic drive_sel_b;
      logic option_sel_a_n;
      logic option_sel_b_n;
      logic option_pair_b_n;
      logic eject_n;
      logic eject_mask_n;
      logic led_blink_n;
   } sample_type;

   // Pin-side state after one sample.
   typedef struct packed {
      logic [1:0] host_sel;
      logic [1:0] rpm300;
      logic [1:0] eject_pulse;
      logic [1:0] masked;
      logic [1:0] blink;
   } pin_result_type;

   // Previous pins: bit0 sel A, bit1 sel B, bit2 opt A n, bit3 opt B n.
   localparam logic [3:0] PREV_PINS_RESET = 4'b1100;

endpackage

// File: rtl/core/fosq_filter.sv
// Tick-driven hysteresis filter on one drive's double option assertion.
module fosq_filter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      both,
   input  logic [fosq_pkg::TICK_W-1:0] assert_ticks,
   input  logic [fosq_pkg::TICK_W-1:0] deassert_ticks,
   output logic                      quad_cur,
   output logic                      quad_nxt
);
   import fosq_pkg::*;

   logic              quad_ff, quad_in;
   logic              active_ff, active_in;
   logic [TICK_W-1:0] count_ff, count_in;
   logic [TICK_W-1:0] count_inc;
   logic [TICK_W-1:0] limit;
   logic              want_change;

   assign want_change = quad_ff ? !both : both;
   assign limit       = quad_ff ? deassert_ticks : assert_ticks;
   assign count_inc   = (count_ff == RUN_COUNT_MAX) ? count_ff : count_ff + 1'b1;

   always_comb begin
      quad_in   = quad_ff;
      active_in = active_ff;
      count_in  = count_ff;
      if (step) begin
         if (!want_change) begin
            active_in = 1'b0;
            count_in  = '0;
         end else if (!active_ff) begin
            // first tick of a run only arms it
            active_in = 1'b1;
            count_in  = '0;
         end else if (count_inc > limit) begin
            quad_in   = !quad_ff;
            active_in = 1'b0;
            count_in  = '0;
         end else begin
            count_in  = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff   <= 1'b0;
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         quad_ff   <= quad_in;
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   assign quad_cur = quad_ff;
   assign quad_nxt = quad_in;

`ifndef SYNTHESIS
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (count_ff == '0))
      else $error("filter count nonzero while no run is active");
`endif

endmodule

// File: rtl/core/fosq_pins.sv
// Edge detection, select routing, rpm mode and option latches.
module fosq_pins (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  fosq_pkg::sample_type     sample,
   input  logic [1:0]               quad_cur,
   input  logic [1:0]               quad_nxt,
   output fosq_pkg::pin_result_type result
);
   import fosq_pkg::*;

   logic [3:0] prev_pins_ff, pins;
   logic [3:0] rise, fall;
   logic [1:0] host_sel_ff, host_sel_in;
   logic [1:0] rpm_ff, rpm_in;
   logic [1:0] masked_ff, masked_in;
   logic [1:0] blink_ff, blink_in;
   logic [1:0] eject_seen_ff, eject_seen_in;
   logic [1:0] pulse;
   logic [1:0] opt_on;
   logic       eject, mask, blink_req;

   assign pins = {sample.option_sel_b_n, sample.option_sel_a_n,
                  sample.drive_sel_b, sample.drive_sel_a};
   assign rise = pins & ~prev_pins_ff;
   assign fall = prev_pins_ff & ~pins;
   assign opt_on    = {!sample.option_sel_b_n, !sample.option_sel_a_n};
   assign eject     = !sample.eject_n;
   assign mask      = !sample.eject_mask_n;
   assign blink_req = !sample.led_blink_n;

   always_comb begin
      host_sel_in   = host_sel_ff;
      rpm_in        = rpm_ff;
      masked_in     = masked_ff;
      blink_in      = blink_ff;
      eject_seen_in = eject_seen_ff;
      pulse         = '0;

      // A before B: B wins when both selects rise together
      for (int d = 0; d < 2; d++) begin
         if (rise[d]) begin
            rpm_in[d]   = quad_cur[d];
            host_sel_in = 2'(1 << d);
         end else if (fall[d]) begin
            host_sel_in[d] = 1'b0;
         end
      end

      for (int d = 0; d < 2; d++) begin
         if (rise[d+2]) begin
            pulse[d]     = eject_seen_ff[d];
            masked_in[d] = mask;
            blink_in[d]  = blink_req;
         end
         if (opt_on[d]) begin
            eject_seen_in[d] = eject;
         end
      end

      if (sample.tick) begin
         if (sample.drive_sel_a) begin
            rpm_in[0] = quad_nxt[0];
         end
         if (sample.drive_sel_b) begin
            rpm_in[1] = quad_nxt[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff  <= PREV_PINS_RESET;
         host_sel_ff   <= '0;
         rpm_ff        <= '0;
         masked_ff     <= '0;
         blink_ff      <= '0;
         eject_seen_ff <= '0;
      end else if (step) begin
         prev_pins_ff  <= pins;
         host_sel_ff   <= host_sel_in;
         rpm_ff        <= rpm_in;
         masked_ff     <= masked_in;
         blink_ff      <= blink_in;
         eject_seen_ff <= eject_seen_in;
      end
   end

   assign result.host_sel    = host_sel_in;
   assign result.rpm300      = rpm_in;
   assign result.eject_pulse = pulse;
   assign result.masked      = masked_in;
   assign result.blink       = blink_in;

`ifndef SYNTHESIS
   a_one_host_sel: assert property (@(posedge clock) disable iff (reset)
      !(host_sel_ff[0] && host_sel_ff[1]))
      else $error("both host selects driven");
`endif

endmodule

// File: rtl/core/fdd_option_select_qualifier.sv
// Top level of the floppy option-select qualifier.
// Each request is one sample of the drive-select and option-select pins plus a tick
// flag; each request yields exactly one response with the routed host selects, the
// rpm modes, eject pulses, latched mask/blink bits and the filtered quad flags. The
// block is a two-stage pipe (request register, then response register) and takes one
// request per clock while req_stall is low, passing each one from the request register
// to the response register. The response register holds under rsp_stall, and req_stall
// rises only when both stages are full and rsp_stall holds the response. The quad
// filters count ticks against assert_ticks/deassert_ticks, which must be written only
// while no request is in flight.
module fdd_option_select_qualifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [0:0]                      csr_index,
   input  logic [fosq_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_tick,
   input  logic                            req_drive_sel_a,
   input  logic                            req_drive_sel_b,
   input  logic                            req_option_sel_a_n,
   input  logic                            req_option_sel_b_n,
   input  logic                            req_option_pair_b_n,
   input  logic                            req_eject_n,
   input  logic                            req_eject_mask_n,
   input  logic                            req_led_blink_n,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_host_sel_a,
   output logic                            rsp_host_sel_b,
   output logic                            rsp_rpm300_a,
   output logic                            rsp_rpm300_b,
   output logic                            rsp_eject_pulse_a,
   output logic                            rsp_eject_pulse_b,
   output logic                            rsp_masked_a,
   output logic                            rsp_masked_b,
   output logic                            rsp_blink_a,
   output logic                            rsp_blink_b,
   output logic                            rsp_quad_a,
   output logic                            rsp_quad_b
);
   import fosq_pkg::*;

   logic [TICK_W-1:0] assert_ticks_ff, deassert_ticks_ff;
   logic              req_valid_ff;
   sample_type        sample_ff, sample_in;
   logic              rsp_valid_ff;
   pin_result_type    pins_ff, pins_res;
   logic [1:0]        quad_ff;
   logic [1:0]        quad_cur, quad_nxt;
   logic              rsp_load, req_load, step;

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign req_load  = !req_valid_ff || rsp_load;
   assign req_stall = !req_load;
   assign step      = req_valid_ff && rsp_load;

   assign sample_in = '{tick:            req_tick,
                        drive_sel_a:     req_drive_sel_a,
                        drive_sel_b:     req_drive_sel_b,
                        option_sel_a_n:  req_option_sel_a_n,
                        option_sel_b_n:  req_option_sel_b_n,
                        option_pair_b_n: req_option_pair_b_n,
                        eject_n:         req_eject_n,
                        eject_mask_n:    req_eject_mask_n,
                        led_blink_n:     req_led_blink_n};

   always_ff @(posedge clock) begin
      if (reset) begin
         assert_ticks_ff   <= ASSERT_TICKS_RESET;
         deassert_ticks_ff <= DEASSERT_TICKS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ASSERT_TICKS:   assert_ticks_ff   <= csr_wdata;
            CSR_DEASSERT_TICKS: deassert_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_load) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_valid) begin
         sample_ff <= sample_in;
      end
   end

   fosq_filter u_filter_a (
      .clock          (clock),
      .reset          (reset),
      .step           (step && sample_ff.tick),
      .both           (!sample_ff.option_sel_a_n && !sample_ff.option_sel_b_n),
      .assert_ticks   (assert_ticks_ff),
      .deassert_ticks (deassert_ticks_ff),
      .quad_cur       (quad_cur[0]),
      .quad_nxt       (quad_nxt[0])
   );

   fosq_filter u_filter_b (
      .clock          (clock),
      .reset          (reset),
      .step           (step && sample_ff.tick),
      .both           (!sample_ff.option_sel_b_n && !sample_ff.option_pair_b_n),
      .assert_ticks   (assert_ticks_ff),
      .deassert_ticks (deassert_ticks_ff),
      .quad_cur       (quad_cur[1]),
      .quad_nxt       (quad_nxt[1])
   );

   fosq_pins u_pins (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .sample   (sample_ff),
      .quad_cur (quad_cur),
      .quad_nxt (quad_nxt),
      .result   (pins_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pins_ff <= pins_res;
         quad_ff <= quad_nxt;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_host_sel_a    = pins_ff.host_sel[0];
   assign rsp_host_sel_b    = pins_ff.host_sel[1];
   assign rsp_rpm300_a      = pins_ff.rpm300[0];
   assign rsp_rpm300_b      = pins_ff.rpm300[1];
   assign rsp_eject_pulse_a = pins_ff.eject_pulse[0];
   assign rsp_eject_pulse_b = pins_ff.eject_pulse[1];
   assign rsp_masked_a      = pins_ff.masked[0];
   assign rsp_masked_b      = pins_ff.masked[1];
   assign rsp_blink_a       = pins_ff.blink[0];
   assign rsp_blink_b       = pins_ff.blink[1];
   assign rsp_quad_a        = quad_ff[0];
   assign rsp_quad_b        = quad_ff[1];

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free stage");

   a_request_advances: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !(rsp_valid_ff && rsp_stall)) |=> rsp_valid_ff)
      else $error("registered request did not reach the response stage");

   a_rsp_one_host_sel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_host_sel_a && rsp_host_sel_b))
      else $error("response drives both host selects");
`endif

endmodule
